/* rtl/lpc_pkg.sv */
package lpc_pkg;

    // Field widths of the byte stream and of one result word.
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 24;
    localparam int ANGLE_W   = 9;
    localparam int RANGE_W   = 14;
    localparam int QUAL_W    = 6;
    localparam int POS_W     = 16;
    localparam int TRIG_W    = 16;
    localparam int TIDX_W    = 7;

    // Packet framing.
    localparam logic [2:0] HDR_LEN = 3'd5;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUALITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE  = 2'd1;
    localparam logic [QUAL_W-1:0]    MIN_QUALITY_RST = 6'd10;
    localparam logic [BYTE_W-1:0]    SYNC_VALUE_RST  = 8'hA5;

    // Result status codes.
    localparam logic STATUS_POINT    = 1'b0;
    localparam logic STATUS_BAD_SYNC = 1'b1;

    // Queue between the front and back sections.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Scaling: result = round(range * trig / 20480) = round(range * trig / (4096 * 5)).
    localparam int          PROD_W     = RANGE_W + TRIG_W;
    localparam int          DIV_SHIFT  = 12;
    localparam int          QUOT_W     = PROD_W - DIV_SHIFT;
    localparam logic [PROD_W-1:0] ROUND_HALF = 30'd10240;
    localparam int          RECIP_W    = 18;
    localparam int          RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP_5 = 18'd209716;

    // One queued word: an error marker or a decoded sample that passed the filter.
    typedef struct packed {
        logic               status;
        logic [ANGLE_W-1:0] angle;
        logic [RANGE_W-1:0] range;
        logic [QUAL_W-1:0]  quality;
    } entry_t;

    // Folded trig lookup: table index and sign.
    typedef struct packed {
        logic              neg;
        logic [TIDX_W-1:0] idx;
    } fold_t;

    // Sine of whole degrees 0..90 in Q15, rounded to nearest.
    localparam logic [TRIG_W-1:0] SIN_TAB [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

    // Map an angle of 0..359 degrees onto the first quadrant of the sine table.
    function automatic fold_t sin_fold(input logic [ANGLE_W-1:0] a);
        fold_t f;
        logic [ANGLE_W-1:0] t;
        if (a <= 9'd90) begin
            f.neg = 1'b0;
            t     = a;
        end else if (a <= 9'd180) begin
            f.neg = 1'b0;
            t     = 9'd180 - a;
        end else if (a <= 9'd270) begin
            f.neg = 1'b1;
            t     = a - 9'd180;
        end else begin
            f.neg = 1'b1;
            t     = 9'd360 - a;
        end
        f.idx = t[TIDX_W-1:0];
        return f;
    endfunction

endpackage

/* rtl/lpc_front.sv */
module lpc_front import lpc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_rx_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 q_full,
    output logic                 q_push,
    output entry_t               q_entry
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HALTED  = 2'd2;

    logic [1:0]         phase_reg, phase_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [COUNT_W-1:0] plen_reg, plen_next;
    logic [BYTE_W-1:0]  sample_reg [0:4];
    logic [BYTE_W-1:0]  sample_next [0:4];
    logic [QUAL_W-1:0]  min_quality_reg;
    logic [BYTE_W-1:0]  sync_value_reg;

    logic               accept;
    logic               do_decode;
    logic               bad_sync;
    logic [COUNT_W-1:0] count_inc;
    logic [14:0]        angle_sum;
    logic [ANGLE_W-1:0] angle_raw;
    logic [ANGLE_W-1:0] angle_dec;
    logic [15:0]        range_word;
    logic [RANGE_W-1:0] range_dec;
    logic [QUAL_W-1:0]  qual_dec;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign count_inc = byte_count_reg + 24'd1;

    // Framing state machine: header, payload, halted after a bad sync byte.
    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        plen_next       = plen_reg;
        do_decode       = 1'b0;
        bad_sync        = 1'b0;
        for (int i = 0; i < 5; i++) begin
            sample_next[i] = sample_reg[i];
        end
        if (accept) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (byte_count_reg == '0 && s_rx_byte != sync_value_reg) begin
                        bad_sync   = 1'b1;
                        phase_next = PH_HALTED;
                    end else begin
                        sample_next[byte_count_reg[2:0]] = s_rx_byte;
                        if (byte_count_reg[2:0] == HDR_LEN - 3'd1) begin
                            byte_count_next = '0;
                            plen_next = {sample_reg[2], sample_reg[3], s_rx_byte};
                            if ({sample_reg[2], sample_reg[3], s_rx_byte} == '0) begin
                                do_decode = 1'b1;
                            end else begin
                                phase_next = PH_PAYLOAD;
                            end
                        end else begin
                            byte_count_next = count_inc;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (byte_count_reg < {21'd0, HDR_LEN}) begin
                        sample_next[byte_count_reg[2:0]] = s_rx_byte;
                    end
                    if (count_inc == plen_reg) begin
                        byte_count_next = '0;
                        phase_next      = PH_HEADER;
                        do_decode       = 1'b1;
                    end else begin
                        byte_count_next = count_inc;
                    end
                end
                default: begin
                    phase_next = PH_HALTED;
                end
            endcase
        end
    end

    // Sample decode from the updated sample bytes.
    always_comb begin
        qual_dec   = sample_next[0][7:2];
        angle_sum  = {sample_next[2], 7'd0} + {8'd0, sample_next[1][7:1]};
        angle_raw  = angle_sum[14:6];
        angle_dec  = (angle_raw >= 9'd360) ? angle_raw - 9'd360 : angle_raw;
        range_word = {sample_next[4], sample_next[3]};
        range_dec  = range_word[15:2];
    end

    // Queue word: an error marker, or a point that passes the quality and range filter.
    always_comb begin
        q_push  = 1'b0;
        q_entry = '0;
        if (bad_sync) begin
            q_push         = 1'b1;
            q_entry.status = STATUS_BAD_SYNC;
        end else if (do_decode && qual_dec >= min_quality_reg && range_dec != '0) begin
            q_push          = 1'b1;
            q_entry.status  = STATUS_POINT;
            q_entry.angle   = angle_dec;
            q_entry.range   = range_dec;
            q_entry.quality = qual_dec;
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HEADER;
            byte_count_reg  <= '0;
            plen_reg        <= '0;
            min_quality_reg <= MIN_QUALITY_RST;
            sync_value_reg  <= SYNC_VALUE_RST;
            for (int i = 0; i < 5; i++) begin
                sample_reg[i] <= '0;
            end
        end else begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            plen_reg       <= plen_next;
            for (int i = 0; i < 5; i++) begin
                sample_reg[i] <= sample_next[i];
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_MIN_QUALITY: min_quality_reg <= cfg_data[QUAL_W-1:0];
                    CFG_SYNC_VALUE:  sync_value_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

/* rtl/lpc_queue.sv */
module lpc_queue import lpc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    entry_t            slot_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic              do_push;
    logic              do_pop;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == QUEUE_DEPTH[QPTR_W:0]);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Word storage; no reset needed on payload.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/lpc_back.sv */
module lpc_back import lpc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  entry_t                    q_head,
    input  logic                      q_empty,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_status,
    output logic signed [POS_W-1:0]   m_x_pos,
    output logic signed [POS_W-1:0]   m_y_pos,
    output logic [ANGLE_W-1:0]        m_angle_deg,
    output logic [RANGE_W-1:0]        m_range_mm,
    output logic [QUAL_W-1:0]         m_quality
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    entry_t              e1_reg, e2_reg, e3_reg;
    logic                xneg1_reg, yneg1_reg, xneg2_reg, yneg2_reg, xneg3_reg, yneg3_reg;
    logic [TRIG_W-1:0]   cos1_reg, sin1_reg;
    logic [PROD_W-1:0]   px2_reg, py2_reg;
    logic [QUOT_W-1:0]   nx3_reg, ny3_reg;

    logic [ANGLE_W:0]    cos_ang_wide;
    logic [ANGLE_W-1:0]  cos_ang;
    fold_t               sin_f, cos_f;
    logic [PROD_W-1:0]   px_round, py_round;
    logic [QUOT_W+RECIP_W-1:0] qx_prod, qy_prod;
    logic [POS_W-1:0]    qx_mag, qy_mag;
    logic [POS_W-1:0]    x_next, y_next;

    // Stall chain: a stage moves when it is empty or the next one moves.
    assign adv4  = !v4_reg || m_ready;
    assign adv3  = !v3_reg || adv4;
    assign adv2  = !v2_reg || adv3;
    assign adv1  = !v1_reg || adv2;
    assign q_pop = adv1 && !q_empty;

    // Stage 1 logic: fold angle into the table range for sine and cosine.
    always_comb begin
        cos_ang_wide = {1'b0, q_head.angle} + 10'd90;
        cos_ang      = (cos_ang_wide >= 10'd360) ? 9'(cos_ang_wide - 10'd360)
                                                 : cos_ang_wide[ANGLE_W-1:0];
        sin_f        = sin_fold(q_head.angle);
        cos_f        = sin_fold(cos_ang);
    end

    // Stage 3 logic: add half the divisor and drop the power-of-two part.
    assign px_round = px2_reg + ROUND_HALF;
    assign py_round = py2_reg + ROUND_HALF;

    // Stage 4 logic: divide by five through a reciprocal and apply the sign.
    always_comb begin
        qx_prod = {{RECIP_W{1'b0}}, nx3_reg} * {{QUOT_W{1'b0}}, RECIP_5};
        qy_prod = {{RECIP_W{1'b0}}, ny3_reg} * {{QUOT_W{1'b0}}, RECIP_5};
        qx_mag  = qx_prod[RECIP_SHIFT +: POS_W];
        qy_mag  = qy_prod[RECIP_SHIFT +: POS_W];
        x_next  = xneg3_reg ? (~qx_mag + 16'd1) : qx_mag;
        y_next  = yneg3_reg ? (~qy_mag + 16'd1) : qy_mag;
    end

    // Valid bits of the four stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= !q_empty;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // Payload of the four stages.
    always_ff @(posedge aclk) begin
        if (adv1) begin
            e1_reg    <= q_head;
            sin1_reg  <= SIN_TAB[sin_f.idx];
            cos1_reg  <= SIN_TAB[cos_f.idx];
            xneg1_reg <= cos_f.neg;
            yneg1_reg <= !sin_f.neg;
        end
        if (adv2) begin
            e2_reg    <= e1_reg;
            px2_reg   <= {{TRIG_W{1'b0}}, e1_reg.range} * {{RANGE_W{1'b0}}, cos1_reg};
            py2_reg   <= {{TRIG_W{1'b0}}, e1_reg.range} * {{RANGE_W{1'b0}}, sin1_reg};
            xneg2_reg <= xneg1_reg;
            yneg2_reg <= yneg1_reg;
        end
        if (adv3) begin
            e3_reg    <= e2_reg;
            nx3_reg   <= px_round[PROD_W-1:DIV_SHIFT];
            ny3_reg   <= py_round[PROD_W-1:DIV_SHIFT];
            xneg3_reg <= xneg2_reg;
            yneg3_reg <= yneg2_reg;
        end
        if (adv4) begin
            m_status    <= e3_reg.status;
            m_x_pos     <= x_next;
            m_y_pos     <= y_next;
            m_angle_deg <= e3_reg.angle;
            m_range_mm  <= e3_reg.range;
            m_quality   <= e3_reg.quality;
        end
    end

    assign m_valid = v4_reg;

endmodule

/* rtl/lidar_packet_to_cartesian_unit.sv */
// Lidar scan packet decoder: turns a raw lidar byte stream into Cartesian points.
// Input channel (s_valid/s_ready/s_rx_byte) takes one word per cycle while ready. Each
// packet is a five-byte header (sync byte, one byte, 24-bit big-endian payload length)
// and its payload; the first five payload bytes overwrite the held sample bytes.
// Result channel (m_valid/m_ready/m_*) delivers one word per decoded sample that
// passes the quality and nonzero-range filter, or one error word (m_status high,
// all other fields zero) for a bad sync byte; after that, input is ignored.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes register 0
// (minimum quality) or 1 (sync byte value); cfg_ready is always high.
// Path of a result word: when the byte that completes its packet is accepted, the
// decoded word is written to the queue between the byte parser and the arithmetic,
// then passes through table lookup, multiply, round, and divide-by-five registers.
// Throughput: one byte per cycle while s_ready is high, set by the byte parser;
// results leave at up to one per cycle through the four-stage pipeline.
// Reset (aresetn low, synchronous) returns to header parsing, clears the count,
// length and sample bytes, and loads minimum quality 10 and sync value 0xA5.
// When the receiver stalls, the pipeline and the four-word queue fill, and then
// s_ready drops until room frees up; no word is lost.
module lidar_packet_to_cartesian_unit import lpc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [BYTE_W-1:0]       s_rx_byte,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_status,
    output logic signed [POS_W-1:0] m_x_pos,
    output logic signed [POS_W-1:0] m_y_pos,
    output logic [ANGLE_W-1:0]      m_angle_deg,
    output logic [RANGE_W-1:0]      m_range_mm,
    output logic [QUAL_W-1:0]       m_quality,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [BYTE_W-1:0]       cfg_data
);

    logic   q_full, q_empty, q_push, q_pop;
    entry_t q_entry, q_head;

    // Byte parser and sample decode.
    lpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // Decoupling queue.
    lpc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // Polar to Cartesian arithmetic and output register.
    lpc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_x_pos     (m_x_pos),
        .m_y_pos     (m_y_pos),
        .m_angle_deg (m_angle_deg),
        .m_range_mm  (m_range_mm),
        .m_quality   (m_quality)
    );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import lpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int Q4_DIVISOR     = 20480;
    localparam int MAX_REPORTS    = 40;
    localparam real PI            = 3.14159265358979323846;

    // Register indexes that map to nothing in the block.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    typedef enum logic [1:0] {PARSE_HEADER, PARSE_PAYLOAD, PARSE_HALTED} parse_state_t;

    typedef struct packed {
        logic                    status;
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic [ANGLE_W-1:0]      angle;
        logic [RANGE_W-1:0]      range_mm;
        logic [QUAL_W-1:0]       quality;
    } point_t;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [BYTE_W-1:0]       s_rx_byte   = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic                    m_status;
    logic signed [POS_W-1:0] m_x_pos;
    logic signed [POS_W-1:0] m_y_pos;
    logic [ANGLE_W-1:0]      m_angle_deg;
    logic [RANGE_W-1:0]      m_range_mm;
    logic [QUAL_W-1:0]       m_quality;
    logic                    cfg_valid   = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [BYTE_W-1:0]       cfg_data    = '0;

    // Predicted packet parser state and configuration copy.
    parse_state_t      pkt_state;
    logic [COUNT_W-1:0] pkt_count;
    logic [COUNT_W-1:0] pkt_len;
    logic [7:0]         pkt_bytes [0:4];
    logic [QUAL_W-1:0]  cfg_min_quality;
    logic [BYTE_W-1:0]  cfg_sync;

    point_t expected_points [$];

    int mismatches   = 0;
    int idle_cycles  = 0;
    int bytes_sent   = 0;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;

    lidar_packet_to_cartesian_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_x_pos     (m_x_pos),
        .m_y_pos     (m_y_pos),
        .m_angle_deg (m_angle_deg),
        .m_range_mm  (m_range_mm),
        .m_quality   (m_quality),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The receiver stalls at random according to the current idle rate.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Sine of a whole-degree angle in Q15, folded onto the first quadrant.
    function automatic int sine_q15(input int deg);
        int fold;
        int mag;
        deg = deg % 360;
        if (deg <= 90) begin
            fold = deg;
        end else if (deg <= 180) begin
            fold = 180 - deg;
        end else if (deg <= 270) begin
            fold = deg - 180;
        end else begin
            fold = 360 - deg;
        end
        mag = $rtoi(32768.0 * $sin(fold * PI / 180.0) + 0.5);
        return (deg > 180) ? -mag : mag;
    endfunction

    // Range times a Q15 factor, divided down to Q.4 centimeters, rounded half away.
    function automatic int scale_to_q4(input int range_val, input int trig);
        longint mag;
        longint r;
        mag = (trig < 0) ? -trig : trig;
        r   = (range_val * mag + Q4_DIVISOR / 2) / Q4_DIVISOR;
        return (trig < 0) ? int'(-r) : int'(r);
    endfunction

    // Decode the held sample and queue a point if it passes the filter.
    function automatic void decode_sample();
        int     q;
        int     a;
        int     d;
        point_t p;
        q = int'(pkt_bytes[0]) >> 2;
        a = (((int'(pkt_bytes[1]) >> 1) + (int'(pkt_bytes[2]) << 7)) >> 6) % 360;
        d = (int'(pkt_bytes[3]) + (int'(pkt_bytes[4]) << 8)) >> 2;
        if (q < cfg_min_quality || d == 0) begin
            return;
        end
        p.status   = STATUS_POINT;
        p.x_pos    = POS_W'(scale_to_q4(d, sine_q15(a + 90)));
        p.y_pos    = POS_W'(-scale_to_q4(d, sine_q15(a)));
        p.angle    = ANGLE_W'(a);
        p.range_mm = RANGE_W'(d);
        p.quality  = QUAL_W'(q);
        expected_points.push_back(p);
    endfunction

    // Advance the predicted parser by one accepted byte.
    function automatic void parse_rx_byte(input logic [7:0] b);
        point_t err;
        case (pkt_state)
            PARSE_HEADER: begin
                if (pkt_count == 0 && b != cfg_sync) begin
                    pkt_state  = PARSE_HALTED;
                    err        = '0;
                    err.status = STATUS_BAD_SYNC;
                    expected_points.push_back(err);
                end else begin
                    if (pkt_count < HDR_LEN) begin
                        pkt_bytes[pkt_count[2:0]] = b;
                    end
                    pkt_count = pkt_count + 1'b1;
                    if (pkt_count >= HDR_LEN) begin
                        pkt_count = '0;
                        pkt_len   = {pkt_bytes[2], pkt_bytes[3], pkt_bytes[4]};
                        if (pkt_len == 0) begin
                            decode_sample();
                        end else begin
                            pkt_state = PARSE_PAYLOAD;
                        end
                    end
                end
            end
            PARSE_PAYLOAD: begin
                if (pkt_count < HDR_LEN) begin
                    pkt_bytes[pkt_count[2:0]] = b;
                end
                pkt_count = pkt_count + 1'b1;
                if (pkt_count == pkt_len) begin
                    pkt_count = '0;
                    pkt_state = PARSE_HEADER;
                    decode_sample();
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Compare one delivered word with the oldest predicted point.
    task automatic check_point();
        point_t got;
        point_t want;
        got = '{m_status, m_x_pos, m_y_pos, m_angle_deg, m_range_mm, m_quality};
        if (expected_points.size() == 0) begin
            report_mismatch($sformatf("unexpected result word, status %0d x %0d y %0d",
                got.status, got.x_pos, got.y_pos));
            return;
        end
        want = expected_points.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.x_pos !== want.x_pos)
            report_mismatch($sformatf("x_pos %0d, expected %0d", got.x_pos, want.x_pos));
        if (got.y_pos !== want.y_pos)
            report_mismatch($sformatf("y_pos %0d, expected %0d", got.y_pos, want.y_pos));
        if (got.angle !== want.angle)
            report_mismatch($sformatf("angle_deg %0d, expected %0d", got.angle, want.angle));
        if (got.range_mm !== want.range_mm)
            report_mismatch($sformatf("range_mm %0d, expected %0d",
                got.range_mm, want.range_mm));
        if (got.quality !== want.quality)
            report_mismatch($sformatf("quality %0d, expected %0d",
                got.quality, want.quality));
    endtask

    // Monitor: track config writes and bytes, check results, and watch for a hang.
    always @(posedge aclk) begin
        if (!aresetn) begin
            pkt_state       = PARSE_HEADER;
            pkt_count       = '0;
            pkt_len         = '0;
            for (int i = 0; i < 5; i++) pkt_bytes[i] = 8'h00;
            cfg_min_quality = 6'd10;
            cfg_sync        = 8'hA5;
            expected_points.delete();
            idle_cycles     = 0;
        end else begin
            if (s_valid && s_ready) begin
                parse_rx_byte(s_rx_byte);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_QUALITY: cfg_min_quality = cfg_data[QUAL_W-1:0];
                    CFG_SYNC_VALUE:  cfg_sync        = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                check_point();
            end
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                    WATCHDOG_LIMIT, expected_points.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Send one byte; called at a falling edge, returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Header with the current sync byte, then the payload; words past five are random.
    task automatic send_packet(input logic [7:0] hdr1, input logic [23:0] len,
                               input logic [39:0] smp);
        logic [7:0] b;
        send_byte(cfg_sync);
        send_byte(hdr1);
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (int unsigned i = 0; i < len; i++) begin
            if (i < 5) begin
                b = smp[8*i +: 8];
            end else begin
                b = 8'($urandom);
            end
            send_byte(b);
        end
    endtask

    // Build five sample bytes that decode to the given quality, angle and range.
    function automatic logic [39:0] sample_word(input int q, input int ang,
                                                input int range_val);
        logic [5:0]  a_low;
        logic [1:0]  r_low;
        logic [1:0]  q_low;
        logic        b1_low;
        logic [14:0] araw;
        logic [15:0] rraw;
        a_low  = 6'($urandom_range(63));
        r_low  = 2'($urandom_range(3));
        q_low  = 2'($urandom_range(3));
        b1_low = 1'($urandom_range(1));
        araw   = {ang[8:0], a_low};
        rraw   = {range_val[13:0], r_low};
        return {rraw[15:8], rraw[7:0], araw[14:7], araw[6:0], b1_low, q[5:0], q_low};
    endfunction

    // Stop sending until every predicted point has been delivered.
    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_points.size() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Let the block go idle, including samples that are still being dropped, then write.
    task automatic reconfigure(input logic [7:0] min_q, input logic [7:0] sync);
        drain_results(SETTLE_CYCLES);
        write_reg(CFG_MIN_QUALITY, min_q);
        write_reg(CFG_SYNC_VALUE, sync);
    endtask

    // Hand-picked packets under the reset configuration.
    task automatic test_directed_packets();
        // Quality right at the minimum passes, one below is dropped.
        send_packet(8'h00, 24'd5, sample_word(10, 0, 1));
        send_packet(8'hFF, 24'd5, sample_word(9, 45, 1000));
        // Quadrant edges and the top of the range.
        send_packet(8'h12, 24'd5, sample_word(63, 90, 16383));
        send_packet(8'h34, 24'd5, sample_word(20, 180, 8000));
        send_packet(8'h56, 24'd5, sample_word(20, 270, 12345));
        send_packet(8'h78, 24'd5, sample_word(30, 359, 500));
        // Raw angles of 360 and above wrap around.
        send_packet(8'h9A, 24'd5, sample_word(30, 360, 700));
        send_packet(8'hBC, 24'd5, sample_word(45, 511, 2));
        // A zero range is dropped.
        send_packet(8'hDE, 24'd5, sample_word(40, 100, 0));
        // All-ones and all-zeros samples.
        send_packet(8'hFF, 24'd5, {40{1'b1}});
        send_packet(8'h00, 24'd5, 40'h0);
        // A zero length decodes the header bytes at once.
        send_packet(8'hC3, 24'd0, 40'h0);
        // Short payloads leave header bytes in the sample.
        send_packet(8'h7F, 24'd1, sample_word(50, 10, 10));
        send_packet(8'hA0, 24'd3, sample_word(12, 200, 10));
        // Longer payloads: words past the fifth are counted but not stored.
        send_packet(8'h55, 24'd9, sample_word(33, 33, 3333));
        send_packet(8'hAA, 24'd12, sample_word(63, 300, 16000));
        // Hold off until every point has come out.
        drain_results(0);
    endtask

    // Well-formed packets with random content and mostly five-word payloads.
    task automatic test_random_stream(input int n_bytes);
        int first_byte;
        int pick;
        int len;
        int q;
        int range_val;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                len = 0;
            end else if (pick < 15) begin
                len = $urandom_range(4, 1);
            end else if (pick < 27) begin
                len = $urandom_range(40, 6);
            end else begin
                len = 5;
            end
            if ($urandom_range(1)) begin
                q = $urandom_range(63, cfg_min_quality);
            end else begin
                q = $urandom_range(63);
            end
            range_val = ($urandom_range(15) == 0) ? 0 : $urandom_range(16383);
            send_packet(8'($urandom), 24'(len),
                        sample_word(q, $urandom_range(511), range_val));
            if ($urandom_range(19) == 0) begin
                drain_results(0);
            end
        end
    endtask

    // A payload long enough to use the middle byte of the length field.
    task automatic test_long_payload();
        send_packet(8'($urandom), 24'h000104, sample_word(63, 123, 9999));
        send_packet(8'($urandom), 24'd5, sample_word(40, 222, 4321));
    endtask

    // Writes to unused indexes must leave the filter and sync byte alone.
    task automatic test_unused_registers();
        drain_results(SETTLE_CYCLES);
        write_reg(CFG_UNUSED_A, 8'h00);
        write_reg(CFG_UNUSED_B, 8'hFF);
        send_packet(8'h11, 24'd5, sample_word(37, 77, 777));
        send_packet(8'h22, 24'd5, sample_word(36, 88, 888));
    endtask

    // A bad sync byte gives one error word, after which everything is ignored.
    task automatic test_bad_sync();
        drain_results(SETTLE_CYCLES);
        send_byte(cfg_sync ^ 8'h5A);
        send_packet(8'h33, 24'd5, sample_word(63, 45, 5000));
        for (int i = 0; i < 20; i++) send_byte(8'($urandom));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Sender idles lightly, receiver stalls half the time.
        src_idle_pct = 14;
        dst_idle_pct = 50;
        test_directed_packets();
        reconfigure(8'd0, 8'h00);
        test_random_stream(70);

        // Sender idles heavily, receiver stalls lightly.
        src_idle_pct = 50;
        dst_idle_pct = 14;
        reconfigure(8'd63, 8'hFF);
        test_random_stream(70);

        // Full rate on both sides.
        src_idle_pct = 0;
        dst_idle_pct = 0;
        reconfigure(8'd37, 8'hA5);
        test_random_stream(70);
        test_long_payload();
        test_unused_registers();
        test_bad_sync();

        drain_results(SETTLE_CYCLES);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/lpc_pkg.sv
rtl/lpc_front.sv
rtl/lpc_queue.sv
rtl/lpc_back.sv
rtl/lidar_packet_to_cartesian_unit.sv
tb/sv/tb.sv
